/* design/mcbp_pkg.sv */
package mcbp_pkg;

	// Default sizes
	localparam int DEF_BUFFER_BYTES = 256;
	localparam int DEF_PIPE_COUNT   = 8;

	// Slots reachable through the 3-bit pipe index
	localparam int ADDRESSABLE = 8;

	// Operation codes
	localparam logic [2:0] FN_ALLOC    = 3'd0;
	localparam logic [2:0] FN_CLOSE_RD = 3'd1;
	localparam logic [2:0] FN_CLOSE_WR = 3'd2;
	localparam logic [2:0] FN_READ     = 3'd3;
	localparam logic [2:0] FN_WRITE    = 3'd4;

	// Result status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_EOF    = 3'd1;
	localparam logic [2:0] ST_BLOCK  = 3'd2;
	localparam logic [2:0] ST_BROKEN = 3'd3;
	localparam logic [2:0] ST_NOSLOT = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RDWAIT,
		S_RESP
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take;     // register the incoming word
		logic exec;     // carry out the operation
		logic capture;  // latch the byte read from the store
		logic load;     // move the result to the output register
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic pop;       // operation reads the byte store
		logic out_busy;  // output register full and stalled
	} ctl_sts_t;

endpackage

/* design/mcbp_ram.sv */
module mcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/mcbp_ctl.sv */
module mcbp_ctl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mcbp_pkg::ctl_sts_t   sts,
	output mcbp_pkg::ctl_cmd_t   cmd
);

	import mcbp_pkg::*;

	state_t state_q;
	state_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nx = sts.pop ? S_RDWAIT : S_RESP;
			end
			S_RDWAIT: begin
				state_nx = S_RESP;
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_RDWAIT: begin
				cmd.capture = 1'b1;
			end
			S_RESP: begin
				cmd.load = !sts.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* design/mcbp_dp.sv */
module mcbp_dp #(
	parameter int BUFFER_BYTES = mcbp_pkg::DEF_BUFFER_BYTES,
	parameter int PIPE_COUNT   = mcbp_pkg::DEF_PIPE_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mcbp_pkg::ctl_cmd_t cmd,
	output mcbp_pkg::ctl_sts_t sts,
	input  logic [2:0]         func,
	input  logic [2:0]         pipe_index,
	input  logic [7:0]         write_data,
	input  logic               first_of_call,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [7:0]         read_data,
	output logic [2:0]         slot
);

	import mcbp_pkg::*;

	localparam int SLOTS = (PIPE_COUNT < ADDRESSABLE) ? PIPE_COUNT : ADDRESSABLE;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW    = $clog2(BUFFER_BYTES);
	localparam int DEPTH = SLOTS * BUFFER_BYTES;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [3:0]    SLOTS_LIM = 4'(SLOTS);
	localparam logic [PW-1:0] PTR_LAST  = PW'(BUFFER_BYTES - 1);

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		logic [PW-1:0] n;
		n = (p == PTR_LAST) ? '0 : p + PW'(1);
		return n;
	endfunction

	// Operation held for execution
	logic [2:0] func_q;
	logic [2:0] idx_q;
	logic [7:0] wdata_q;
	logic       first_q;

	// Per-slot pipe state
	logic [PW-1:0] wp_q [SLOTS];
	logic [PW-1:0] rp_q [SLOTS];
	logic [SLOTS-1:0] ro_q;
	logic [SLOTS-1:0] wo_q;

	// Pending result and output register
	logic [2:0] res_status_q;
	logic [2:0] res_slot_q;
	logic [7:0] res_rdata_q;
	logic       out_valid_q;
	logic [2:0] out_status_q;
	logic [7:0] out_rdata_q;
	logic [2:0] out_slot_q;

	// Decode
	logic          hit;
	logic [SW-1:0] li;
	logic [PW-1:0] wp;
	logic [PW-1:0] rp;
	logic          empty;
	logic          full;
	logic          any_free;
	logic [SW-1:0] free_slot;
	logic          do_alloc;
	logic          do_clr_rd;
	logic          do_clr_wr;
	logic          do_pop;
	logic          do_push;
	logic [2:0]    nx_status;
	logic [2:0]    nx_slot;
	logic [AW-1:0] base;
	logic [7:0]    ram_rdata;

	// Register the accepted word
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q  <= func;
			idx_q   <= pipe_index;
			wdata_q <= write_data;
			first_q <= first_of_call;
		end
	end

	// Look up the addressed slot
	assign hit   = {1'b0, idx_q} < SLOTS_LIM;
	assign li    = idx_q[SW-1:0];
	assign wp    = wp_q[li];
	assign rp    = rp_q[li];
	assign empty = (wp == rp);
	assign full  = (ring_next(wp) == rp);

	// Find the lowest slot with both ends closed
	always_comb begin
		any_free  = 1'b0;
		free_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!ro_q[i] && !wo_q[i]) begin
				any_free  = 1'b1;
				free_slot = SW'(i);
			end
		end
	end

	// Decide the operation outcome
	always_comb begin
		do_alloc  = 1'b0;
		do_clr_rd = 1'b0;
		do_clr_wr = 1'b0;
		do_pop    = 1'b0;
		do_push   = 1'b0;
		nx_status = ST_OK;
		nx_slot   = '0;
		case (func_q)
			FN_ALLOC: begin
				if (any_free) begin
					do_alloc = 1'b1;
					nx_slot  = 3'(free_slot);
				end else begin
					nx_status = ST_NOSLOT;
				end
			end
			FN_CLOSE_RD: begin
				do_clr_rd = hit;
			end
			FN_CLOSE_WR: begin
				do_clr_wr = hit;
			end
			FN_READ: begin
				if (hit && !empty) begin
					do_pop = 1'b1;
				end else if (!first_q) begin
					nx_status = ST_DONE;
				end else if (hit && wo_q[li]) begin
					nx_status = ST_BLOCK;
				end else begin
					nx_status = ST_EOF;
				end
			end
			FN_WRITE: begin
				if (!hit || !ro_q[li]) begin
					nx_status = ST_BROKEN;
				end else if (full) begin
					nx_status = ST_BLOCK;
				end else begin
					do_push = 1'b1;
				end
			end
			default: begin
				nx_status = ST_OK;
			end
		endcase
	end

	// Update pointers and end flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ro_q <= '0;
			wo_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				wp_q[i] <= '0;
				rp_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			if (do_alloc) begin
				ro_q[free_slot] <= 1'b1;
				wo_q[free_slot] <= 1'b1;
				wp_q[free_slot] <= '0;
				rp_q[free_slot] <= '0;
			end
			if (do_clr_rd) begin
				ro_q[li] <= 1'b0;
			end
			if (do_clr_wr) begin
				wo_q[li] <= 1'b0;
			end
			if (do_pop) begin
				rp_q[li] <= ring_next(rp);
			end
			if (do_push) begin
				wp_q[li] <= ring_next(wp);
			end
		end
	end

	// Byte store shared by all pipes, one ring per slot
	assign base = AW'(li) * AW'(BUFFER_BYTES);

	mcbp_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.exec && do_push),
		.waddr (base + AW'(wp)),
		.wdata (wdata_q),
		.re    (cmd.exec && do_pop),
		.raddr (base + AW'(rp)),
		.rdata (ram_rdata)
	);

	// Hold the result until the output register is free
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= nx_status;
			res_slot_q   <= nx_slot;
			res_rdata_q  <= '0;
		end
		if (cmd.capture) begin
			res_rdata_q <= ram_rdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_rdata_q  <= res_rdata_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign sts.pop      = do_pop;
	assign sts.out_busy = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign read_data = out_rdata_q;
	assign slot      = out_slot_q;

endmodule

/* design/multi_channel_byte_pipe_core.sv */
// Table of byte pipes, one operation per input word.
// Input channel: in_valid / in_stall with func, pipe_index, write_data and
// first_of_call. Output channel: out_valid / out_stall with status,
// read_data and slot; every input word gives exactly one output word.
// Operations: allocate the lowest free slot, close the read or write end,
// read one byte, write one byte. Each pipe is a ring of BUFFER_BYTES bytes
// holding at most BUFFER_BYTES - 1; only the first eight slots can be used.
// Each word is registered, then executed, and its result is loaded into the
// output register; a read that pops a byte passes through a store read
// state in between (the byte store has a registered read port). The block
// works on one word at a time: the controller sequence execute, store read,
// result load must finish before a new word is taken.
// A finished word waits in the output register while the next input word
// is accepted; if out_stall holds the register full, the following word
// waits in the result hold stage and in_stall stays high.
// Reset clears all end flags and ring pointers and empties the output
// register; the byte store itself is not cleared and needs no sweep.
module multi_channel_byte_pipe_core #(
	parameter int BUFFER_BYTES = mcbp_pkg::DEF_BUFFER_BYTES,
	parameter int PIPE_COUNT   = mcbp_pkg::DEF_PIPE_COUNT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] func,
	input  logic [2:0] pipe_index,
	input  logic [7:0] write_data,
	input  logic       first_of_call,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] read_data,
	output logic [2:0] slot
);

	import mcbp_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// Sequencer
	mcbp_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Pipe state, byte store and result registers
	mcbp_dp #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.PIPE_COUNT   (PIPE_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.pipe_index    (pipe_index),
		.write_data    (write_data),
		.first_of_call (first_of_call),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.read_data     (read_data),
		.slot          (slot)
	);

	// Never overwrite a result that is still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(out_valid && out_stall))
		else $error("result loaded over a stalled output word");

	// An accepted word is executed on the next cycle
	a_take_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> cmd.exec)
		else $error("accepted word not executed");

	// Store data is captured only after a popping read
	a_capture_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> $past(cmd.exec && sts.pop))
		else $error("byte captured without a pop");

	// A new output word only follows a result load
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.load))
		else $error("output valid without a result load");

endmodule
